/* rtl/core/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with asynchronous reset disable
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");

// plain expression that must hold at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	`ASSERT_CLK(label, clk, rst_n, (expr))

`endif

/* rtl/core/wbp_pkg.sv */
`default_nettype none
package wbp_pkg;

	localparam int MAX_BUCKETS_DEF = 512;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int NB_W    = 10;
	localparam int TS_W    = 32;
	localparam int IDX_W   = 9;
	localparam int LEVEL_W = 16;
	localparam int SUM_W   = 48;
	localparam int CNT_W   = 32;
	localparam int DIV_W   = 32;
	localparam int STEP_W  = 6;
	localparam int RAD_W   = 50;
	localparam int ROOT_W  = 25;
	localparam int PROD_W  = 42;

	localparam logic [NB_W-1:0] NB_RESET = 10'd500;
	localparam logic [TS_W-1:0] TS_RESET = 32'd1;

	localparam logic REG_NUM_BUCKETS   = 1'b0;
	localparam logic REG_TOTAL_SAMPLES = 1'b1;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam int Q_DEPTH = 2;

	typedef struct packed {
		logic             op;
		logic             last;
		logic [IDX_W-1:0] idx;
	} req_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  rem_init;
		logic [DIV_W-1:0]  lo;
		logic [STEP_W-1:0] steps;
		logic [DIV_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PUSH_MUL,
		ST_PUSH_CHK,
		ST_PUSH_DIV,
		ST_PUSH_RD,
		ST_PUSH_WR,
		ST_PUSH_END,
		ST_FIN_RD,
		ST_FIN_CHK,
		ST_FIN_DIV,
		ST_FIN_WR,
		ST_RD_WAIT,
		ST_RD_DIV,
		ST_RD_DIVW,
		ST_RD_MUL1,
		ST_RD_MUL2,
		ST_RD_ROOT,
		ST_RD_SQRT,
		ST_RD_OUT
	} back_state_t;

endpackage
`default_nettype wire

/* rtl/core/wbp_div.sv */
`default_nettype none
// restoring divider, one quotient bit per cycle
module wbp_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire wbp_pkg::div_req_t req,
	output wbp_pkg::div_rsp_t      rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic [wbp_pkg::STEP_W-1:0]     cnt_q;
	logic [wbp_pkg::DIV_W-1:0]      rem_q;
	logic [wbp_pkg::DIV_W-1:0]      lo_q;
	logic [wbp_pkg::DIV_W-1:0]      quot_q;
	logic [wbp_pkg::DIV_W-1:0]      d_q;
	logic [wbp_pkg::DIV_W:0]        shifted;
	logic                           ge;
	logic [wbp_pkg::DIV_W:0]        diff;

	assign shifted = {rem_q, lo_q[wbp_pkg::DIV_W-1]};
	assign ge      = shifted >= {1'b0, d_q};
	assign diff    = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == wbp_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem_init;
			lo_q   <= req.lo;
			d_q    <= req.divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[wbp_pkg::DIV_W-1:0] : shifted[wbp_pkg::DIV_W-1:0];
			lo_q   <= {lo_q[wbp_pkg::DIV_W-2:0], 1'b0};
			quot_q <= {quot_q[wbp_pkg::DIV_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule
`default_nettype wire

/* rtl/core/wbp_isqrt.sv */
`default_nettype none
// integer square root, one bit pair per cycle
module wbp_isqrt (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [wbp_pkg::RAD_W-1:0]  x,
	output logic                            done,
	output logic [wbp_pkg::ROOT_W-1:0]      root
);

	localparam int REM_W = wbp_pkg::ROOT_W + 3;

	logic                         busy_q;
	logic                         done_q;
	logic [4:0]                   cnt_q;
	logic [wbp_pkg::RAD_W-1:0]    x_q;
	logic [REM_W-1:0]             rem_q;
	logic [wbp_pkg::ROOT_W-1:0]   root_q;
	logic [REM_W-1:0]             rem_sh;
	logic [REM_W-1:0]             trial;
	logic                         ge;

	assign rem_sh = {rem_q[REM_W-3:0], x_q[wbp_pkg::RAD_W-1 -: 2]};
	assign trial  = REM_W'({root_q, 2'b01});
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(wbp_pkg::ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[wbp_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[wbp_pkg::ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

/* rtl/core/wbp_front.sv */
`default_nettype none
// input side: takes requests, folds the sample to its magnitude, queues them
module wbp_front #(
	parameter int SAMPLE_BITS = wbp_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       operation,
	input  wire logic [SAMPLE_BITS-1:0]     sample,
	input  wire logic                       last_sample,
	input  wire logic [wbp_pkg::IDX_W-1:0]  bucket_index,
	output logic                            q_valid,
	output wbp_pkg::req_t                   q_req,
	output logic [SAMPLE_BITS:0]            q_mag,
	input  wire logic                       pop
);

	wbp_pkg::req_t          req_mem [wbp_pkg::Q_DEPTH];
	logic [SAMPLE_BITS:0]   mag_mem [wbp_pkg::Q_DEPTH];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             count_q;
	logic                   push;
	logic                   do_pop;
	logic [SAMPLE_BITS:0]   mag;
	wbp_pkg::req_t          in_req;

	assign mag = sample[SAMPLE_BITS-1]
		? ({1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, sample})
		: {1'b0, sample};

	assign in_req.op   = operation;
	assign in_req.last = last_sample && (operation == wbp_pkg::OP_PUSH);
	assign in_req.idx  = bucket_index;

	assign in_ready = count_q != 2'(wbp_pkg::Q_DEPTH);
	assign push     = in_valid && in_ready;
	assign q_valid  = count_q != 2'd0;
	assign do_pop   = pop && q_valid;
	assign q_req    = req_mem[rd_ptr_q];
	assign q_mag    = mag_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			req_mem[wr_ptr_q] <= in_req;
			mag_mem[wr_ptr_q] <= mag;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/wbp_back.sv */
`default_nettype none
// execution side: bucket store, finish pass and level computation
module wbp_back #(
	parameter int MAX_BUCKETS = wbp_pkg::MAX_BUCKETS_DEF,
	parameter int SAMPLE_BITS = wbp_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	input  wire wbp_pkg::req_t               q_req,
	input  wire logic [SAMPLE_BITS:0]        q_mag,
	output logic                             pop,
	input  wire logic [wbp_pkg::NB_W-1:0]    num_buckets,
	input  wire logic [wbp_pkg::TS_W-1:0]    total_samples,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [wbp_pkg::IDX_W-1:0]        read_bucket,
	output logic [wbp_pkg::LEVEL_W-1:0]      level
);

	localparam int ADDR_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int AVG_W  = (SAMPLE_BITS > 17) ? SAMPLE_BITS : 17;
	localparam int MAG_W  = SAMPLE_BITS + 1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_BUCKETS - 1);
	localparam logic [wbp_pkg::STEP_W-1:0] BKT_STEPS = wbp_pkg::STEP_W'(ADDR_W);
	localparam logic [wbp_pkg::STEP_W-1:0] AVG_STEPS = wbp_pkg::STEP_W'(AVG_W);
	localparam logic [wbp_pkg::STEP_W-1:0] LVL_STEPS = wbp_pkg::STEP_W'(17);

	wbp_pkg::back_state_t state_q, state_d;

	logic [wbp_pkg::SUM_W-1:0] sum_mem [MAX_BUCKETS];
	logic [wbp_pkg::CNT_W-1:0] cnt_mem [MAX_BUCKETS];
	logic [AVG_W-1:0]          avg_mem [MAX_BUCKETS];

	logic [wbp_pkg::SUM_W-1:0]  sum_rd_q;
	logic [wbp_pkg::CNT_W-1:0]  cnt_rd_q;
	logic [AVG_W-1:0]           avg_rd_q;
	logic [ADDR_W-1:0]          addr_q;
	logic                       phase_q;
	logic [wbp_pkg::CNT_W-1:0]  counter_q;
	logic [AVG_W-1:0]           largest_q;
	logic [MAG_W-1:0]           mag_q;
	logic                       last_q;
	logic [wbp_pkg::IDX_W-1:0]  idx_q;
	logic [wbp_pkg::PROD_W-1:0] p_q;
	logic [wbp_pkg::PROD_W-1:0] lim_q;
	logic [AVG_W-1:0]           avg_q;
	logic [16:0]                t_q;
	logic [33:0]                sq_q;
	logic [wbp_pkg::RAD_W-1:0]  cube_q;
	logic [wbp_pkg::LEVEL_W-1:0] lvl_q;
	logic                       out_valid_q;
	logic [wbp_pkg::IDX_W-1:0]  read_bucket_q;
	logic [wbp_pkg::LEVEL_W-1:0] level_q;

	logic [wbp_pkg::NB_W-1:0]   nb_eff;
	logic [wbp_pkg::TS_W-1:0]   ts_eff;
	logic                       rd_zero;
	logic                       mem_we;
	logic                       avg_we;
	logic [wbp_pkg::SUM_W-1:0]  sum_wd;
	logic [wbp_pkg::CNT_W-1:0]  cnt_wd;
	logic [wbp_pkg::SUM_W:0]    sum_add;
	logic                       sqrt_start;
	logic                       sqrt_done;
	logic [wbp_pkg::ROOT_W-1:0] sqrt_root;
	logic [16:0]                root_sh;
	logic [31:0]                idx_ext;
	wbp_pkg::div_req_t          div_req;
	wbp_pkg::div_rsp_t          div_rsp;

	wbp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	wbp_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.x      (cube_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	assign nb_eff = (num_buckets == '0) ? wbp_pkg::NB_W'(1)
		: ((32'(num_buckets) > MAX_BUCKETS) ? wbp_pkg::NB_W'(MAX_BUCKETS) : num_buckets);
	assign ts_eff = (total_samples == '0) ? wbp_pkg::TS_W'(1) : total_samples;

	assign idx_ext = 32'(q_req.idx);
	assign rd_zero = !phase_q || (idx_ext >= MAX_BUCKETS) || (largest_q == '0);
	assign sum_add = (wbp_pkg::SUM_W+1)'(sum_rd_q) + (wbp_pkg::SUM_W+1)'(mag_q);
	assign root_sh = 17'(sqrt_root >> 8);

	always_comb begin
		state_d = state_q;
		case (state_q)
			wbp_pkg::ST_CLEAR:    if (addr_q == LAST_ADDR) state_d = wbp_pkg::ST_IDLE;
			wbp_pkg::ST_IDLE: begin
				if (pop) begin
					if (q_req.op == wbp_pkg::OP_PUSH)
						state_d = wbp_pkg::ST_PUSH_MUL;
					else if (rd_zero)
						state_d = wbp_pkg::ST_RD_OUT;
					else
						state_d = wbp_pkg::ST_RD_WAIT;
				end
			end
			wbp_pkg::ST_PUSH_MUL: state_d = wbp_pkg::ST_PUSH_CHK;
			wbp_pkg::ST_PUSH_CHK:
				state_d = (p_q < lim_q) ? wbp_pkg::ST_PUSH_DIV : wbp_pkg::ST_PUSH_END;
			wbp_pkg::ST_PUSH_DIV: if (div_rsp.done) state_d = wbp_pkg::ST_PUSH_RD;
			wbp_pkg::ST_PUSH_RD:  state_d = wbp_pkg::ST_PUSH_WR;
			wbp_pkg::ST_PUSH_WR:  state_d = wbp_pkg::ST_PUSH_END;
			wbp_pkg::ST_PUSH_END: state_d = last_q ? wbp_pkg::ST_FIN_RD : wbp_pkg::ST_IDLE;
			wbp_pkg::ST_FIN_RD:   state_d = wbp_pkg::ST_FIN_CHK;
			wbp_pkg::ST_FIN_CHK:
				state_d = (cnt_rd_q == '0) ? wbp_pkg::ST_FIN_WR : wbp_pkg::ST_FIN_DIV;
			wbp_pkg::ST_FIN_DIV:  if (div_rsp.done) state_d = wbp_pkg::ST_FIN_WR;
			wbp_pkg::ST_FIN_WR:
				state_d = (addr_q == LAST_ADDR) ? wbp_pkg::ST_IDLE : wbp_pkg::ST_FIN_RD;
			wbp_pkg::ST_RD_WAIT:  state_d = wbp_pkg::ST_RD_DIV;
			wbp_pkg::ST_RD_DIV:   state_d = wbp_pkg::ST_RD_DIVW;
			wbp_pkg::ST_RD_DIVW:  if (div_rsp.done) state_d = wbp_pkg::ST_RD_MUL1;
			wbp_pkg::ST_RD_MUL1:  state_d = wbp_pkg::ST_RD_MUL2;
			wbp_pkg::ST_RD_MUL2:  state_d = wbp_pkg::ST_RD_ROOT;
			wbp_pkg::ST_RD_ROOT:  state_d = wbp_pkg::ST_RD_SQRT;
			wbp_pkg::ST_RD_SQRT:  if (sqrt_done) state_d = wbp_pkg::ST_RD_OUT;
			wbp_pkg::ST_RD_OUT:   state_d = wbp_pkg::ST_IDLE;
			default:              state_d = wbp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop              = 1'b0;
		mem_we           = 1'b0;
		avg_we           = 1'b0;
		sum_wd           = '0;
		cnt_wd           = '0;
		sqrt_start       = 1'b0;
		div_req.start    = 1'b0;
		div_req.rem_init = 32'(p_q >> ADDR_W);
		div_req.lo       = 32'(p_q[ADDR_W-1:0]) << (wbp_pkg::DIV_W - ADDR_W);
		div_req.steps    = BKT_STEPS;
		div_req.divisor  = ts_eff;
		case (state_q)
			wbp_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
			end
			wbp_pkg::ST_IDLE: begin
				// a read waits until the result register can take its answer
				pop = q_valid && (q_req.op == wbp_pkg::OP_PUSH || !out_valid_q || out_ready);
			end
			wbp_pkg::ST_PUSH_CHK: begin
				div_req.start = p_q < lim_q;
			end
			wbp_pkg::ST_PUSH_WR: begin
				mem_we = 1'b1;
				sum_wd = sum_add[wbp_pkg::SUM_W] ? '1 : sum_add[wbp_pkg::SUM_W-1:0];
				cnt_wd = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + 1'b1;
			end
			wbp_pkg::ST_FIN_CHK: begin
				div_req.start    = cnt_rd_q != '0;
				div_req.rem_init = 32'(sum_rd_q >> AVG_W);
				div_req.lo       = 32'(sum_rd_q[AVG_W-1:0]) << (wbp_pkg::DIV_W - AVG_W);
				div_req.steps    = AVG_STEPS;
				div_req.divisor  = cnt_rd_q;
			end
			wbp_pkg::ST_FIN_WR: begin
				// averages move out, sums and counts start the next load at zero
				mem_we = 1'b1;
				avg_we = 1'b1;
			end
			wbp_pkg::ST_RD_DIV: begin
				div_req.start    = 1'b1;
				div_req.rem_init = 32'(avg_rd_q >> 1);
				div_req.lo       = {avg_rd_q[0], 31'b0};
				div_req.steps    = LVL_STEPS;
				div_req.divisor  = 32'(largest_q);
			end
			wbp_pkg::ST_RD_ROOT: begin
				sqrt_start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sum_mem[addr_q] <= sum_wd;
			cnt_mem[addr_q] <= cnt_wd;
		end
		if (avg_we)
			avg_mem[addr_q] <= avg_q;
		sum_rd_q <= sum_mem[addr_q];
		cnt_rd_q <= cnt_mem[addr_q];
		avg_rd_q <= avg_mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wbp_pkg::ST_CLEAR;
			addr_q      <= '0;
			phase_q     <= 1'b0;
			counter_q   <= '0;
			largest_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == wbp_pkg::ST_RD_OUT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				wbp_pkg::ST_CLEAR: begin
					addr_q <= addr_q + 1'b1;
				end
				wbp_pkg::ST_IDLE: begin
					if (pop && q_req.op == wbp_pkg::OP_PUSH && phase_q) begin
						phase_q   <= 1'b0;
						counter_q <= '0;
						largest_q <= '0;
					end
					if (pop && q_req.op == wbp_pkg::OP_READ)
						addr_q <= idx_ext[ADDR_W-1:0];
				end
				wbp_pkg::ST_PUSH_DIV: begin
					if (div_rsp.done)
						addr_q <= div_rsp.quot[ADDR_W-1:0];
				end
				wbp_pkg::ST_PUSH_END: begin
					if (counter_q != '1)
						counter_q <= counter_q + 1'b1;
					if (last_q) begin
						addr_q    <= '0;
						largest_q <= '0;
					end
				end
				wbp_pkg::ST_FIN_WR: begin
					if (avg_q > largest_q)
						largest_q <= avg_q;
					if (addr_q == LAST_ADDR) begin
						phase_q <= 1'b1;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			wbp_pkg::ST_IDLE: begin
				mag_q  <= q_mag;
				last_q <= q_req.last;
				idx_q  <= q_req.idx;
				lvl_q  <= '0;
			end
			wbp_pkg::ST_PUSH_MUL: begin
				p_q   <= wbp_pkg::PROD_W'(counter_q) * wbp_pkg::PROD_W'(nb_eff);
				lim_q <= wbp_pkg::PROD_W'(ts_eff) * wbp_pkg::PROD_W'(nb_eff);
			end
			wbp_pkg::ST_FIN_CHK: begin
				avg_q <= '0;
			end
			wbp_pkg::ST_FIN_DIV: begin
				if (div_rsp.done)
					avg_q <= div_rsp.quot[AVG_W-1:0];
			end
			wbp_pkg::ST_RD_DIVW: begin
				if (div_rsp.done)
					t_q <= (div_rsp.quot > 32'd65536) ? 17'd65536 : div_rsp.quot[16:0];
			end
			wbp_pkg::ST_RD_MUL1: begin
				sq_q <= 34'(t_q) * 34'(t_q);
			end
			wbp_pkg::ST_RD_MUL2: begin
				// t is at most 2^16, so the cube fits in the radicand
				cube_q <= wbp_pkg::RAD_W'(51'(sq_q) * 51'(t_q));
			end
			wbp_pkg::ST_RD_SQRT: begin
				if (sqrt_done)
					lvl_q <= (root_sh > 17'd65535) ? 16'hFFFF : root_sh[15:0];
			end
			wbp_pkg::ST_RD_OUT: begin
				read_bucket_q <= idx_q;
				level_q       <= lvl_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign read_bucket = read_bucket_q;
	assign level       = level_q;

endmodule
`default_nettype wire

/* rtl/core/waveform_bucket_peaks.sv */
// Waveform overview builder. Push requests carry Q1.15 samples that are summed by magnitude
// into buckets; the request flagged last_sample starts a finish pass that turns every
// bucket into its average and tracks the largest. Read requests return
// (average/largest)^1.5 as Q0.16, or zero before a finished pass. A push runs a bit-serial
// bucket divider of log2(MAX_BUCKETS) steps, which is skipped when the sample falls past the
// last bucket; the last push adds a finish pass that runs a 17-step average division per
// filled bucket and skips it for an empty one. A read runs a 17-step divider, two
// multiplies and a 25-step square root; a read whose level is known to be zero skips them.
// After reset a clearing pass over all MAX_BUCKETS entries runs before any request starts;
// the two-entry input queue still takes requests meanwhile. Registers: num_buckets at
// address 0, total_samples at address 4.
`default_nettype none
module waveform_bucket_peaks #(
	parameter int MAX_BUCKETS = wbp_pkg::MAX_BUCKETS_DEF,
	parameter int SAMPLE_BITS = wbp_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        operation,
	input  wire logic [SAMPLE_BITS-1:0]      sample,
	input  wire logic                        last_sample,
	input  wire logic [wbp_pkg::IDX_W-1:0]   bucket_index,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [wbp_pkg::IDX_W-1:0]        read_bucket,
	output logic [wbp_pkg::LEVEL_W-1:0]      level,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [2:0]                  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	logic [wbp_pkg::NB_W-1:0] nb_q;
	logic [wbp_pkg::TS_W-1:0] ts_q;
	logic                     cfg_wr;
	logic                     q_valid;
	wbp_pkg::req_t            q_req;
	logic [SAMPLE_BITS:0]     q_mag;
	logic                     pop;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_q <= wbp_pkg::NB_RESET;
			ts_q <= wbp_pkg::TS_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == wbp_pkg::REG_NUM_BUCKETS)
				nb_q <= pwdata[wbp_pkg::NB_W-1:0];
			else
				ts_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == wbp_pkg::REG_TOTAL_SAMPLES) ? ts_q : 32'(nb_q);

	wbp_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.sample       (sample),
		.last_sample  (last_sample),
		.bucket_index (bucket_index),
		.q_valid      (q_valid),
		.q_req        (q_req),
		.q_mag        (q_mag),
		.pop          (pop)
	);

	wbp_back #(
		.MAX_BUCKETS (MAX_BUCKETS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_req         (q_req),
		.q_mag         (q_mag),
		.pop           (pop),
		.num_buckets   (nb_q),
		.total_samples (ts_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.read_bucket   (read_bucket),
		.level         (level)
	);

endmodule
`default_nettype wire

/* rtl/core/wbp_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module wbp_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic [wbp_pkg::IDX_W-1:0]  read_bucket,
	input wire logic [wbp_pkg::LEVEL_W-1:0] level,
	input wire logic                       psel,
	input wire logic                       penable,
	input wire logic                       pwrite,
	input wire logic [2:0]                 paddr,
	input wire logic [31:0]                pwdata,
	input wire logic [31:0]                prdata,
	input wire logic                       pready
);

	logic out_wait;
	logic nb_wr;
	logic nb_rd;

	assign out_wait = out_valid && !out_ready;
	assign nb_wr    = psel && penable && pwrite && !paddr[2];
	assign nb_rd    = psel && !pwrite && !paddr[2];

	`ASSERT_CLK(a_out_hold, clk, arst_n, out_wait |=> out_valid)
	`ASSERT_CLK(a_out_stable, clk, arst_n, out_wait |=> $stable(level) && $stable(read_bucket))
	`ASSERT_ALWAYS(a_pready, clk, arst_n, pready)
	// register written then read back on the next cycle
	`ASSERT_CLK(a_nb_readback, clk, arst_n, nb_wr ##1 nb_rd |-> prdata[9:0] == $past(pwdata[9:0]))

endmodule

bind waveform_bucket_peaks wbp_checker u_wbp_checker (.*);
`default_nettype wire
